>>> hw/rtl/npmac_pkg.sv
// Package for the negacyclic polynomial multiply-accumulate block mod q.
// Holds widths, modulus and Barrett constants, opcodes, the tag type and the reduce function.
// No dependencies.
package npmac_pkg;

    localparam int N_COEFFS = 512;
    localparam int ADDR_W   = $clog2(N_COEFFS);

    localparam int OP_W    = 2;
    localparam int IDX_W   = 9;
    localparam int VAL_W   = 20;
    localparam int NOISE_W = 10;
    localparam int WIDE_W  = VAL_W + 2;

    localparam logic [OP_W-1:0] OP_LOAD = 2'd0;
    localparam logic [OP_W-1:0] OP_MAC  = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    localparam logic [WIDE_W-1:0] Q_W  = 22'd724481;
    localparam logic [WIDE_W-1:0] Q2_W = 22'd1448962;

    // Barrett: qhat = ((x >> (VAL_W-1)) * MU) >> (VAL_W+1), MU = floor(2^(2*VAL_W) / q)
    localparam int PROD_W = 2 * VAL_W;
    localparam int BAR_LO = VAL_W - 1;
    localparam int BAR_HI = VAL_W + 1;
    localparam int QH_W   = PROD_W - BAR_LO;
    localparam int MU_W   = 21;
    localparam int T_W    = QH_W + MU_W;
    localparam int QQ_W   = QH_W + VAL_W;
    localparam logic [MU_W-1:0] MU = 21'd1517654;

    localparam int MR_LAT  = 5;
    localparam int TAG_N   = MR_LAT + 1;
    localparam int RD_TAP  = MR_LAT - 1;
    localparam int WB_TAP  = MR_LAT;

    typedef struct packed {
        logic              wrap;
        logic [ADDR_W-1:0] k;
    } t_tag;

    // reduce a value below 3q into [0,q)
    function automatic logic [VAL_W-1:0] reduce3(input logic [WIDE_W-1:0] v);
        logic [WIDE_W-1:0] r;
        if (v >= Q2_W) begin
            r = v - Q2_W;
        end else if (v >= Q_W) begin
            r = v - Q_W;
        end else begin
            r = v;
        end
        return r[VAL_W-1:0];
    endfunction

endpackage

>>> hw/rtl/npmac_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read data.
// No dependencies.
module npmac_ram #(
    parameter int WIDTH = 20,
    parameter int DEPTH = 512
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/npmac_mulred.sv
// Pipelined modular multiplier: p = a*b mod q by Barrett reduction, five register stages.
// Depends on npmac_pkg.
module npmac_mulred (
    input  logic                          i_clk,
    input  logic [npmac_pkg::VAL_W-1:0]   i_a,
    input  logic [npmac_pkg::VAL_W-1:0]   i_b,
    output logic [npmac_pkg::VAL_W-1:0]   o_p
);

    logic [npmac_pkg::PROD_W-1:0] r_prod;
    logic [npmac_pkg::T_W-1:0]    r_t;
    logic [npmac_pkg::WIDE_W-1:0] r_xlo2;
    logic [npmac_pkg::WIDE_W-1:0] r_xlo3;
    logic [npmac_pkg::WIDE_W-1:0] r_qq;
    logic [npmac_pkg::WIDE_W-1:0] r_r;
    logic [npmac_pkg::VAL_W-1:0]  r_p;

    logic [npmac_pkg::T_W-1:0]    t_full;
    logic [npmac_pkg::QQ_W-1:0]   qq_full;

    assign t_full  = npmac_pkg::T_W'(r_prod[npmac_pkg::PROD_W-1:npmac_pkg::BAR_LO])
                   * npmac_pkg::T_W'(npmac_pkg::MU);
    assign qq_full = npmac_pkg::QQ_W'(r_t[npmac_pkg::T_W-1:npmac_pkg::BAR_HI])
                   * npmac_pkg::QQ_W'(npmac_pkg::Q_W);

    always_ff @(posedge i_clk) begin
        r_prod <= npmac_pkg::PROD_W'(i_a) * npmac_pkg::PROD_W'(i_b);
        r_t    <= t_full;
        r_xlo2 <= r_prod[npmac_pkg::WIDE_W-1:0];
        r_qq   <= qq_full[npmac_pkg::WIDE_W-1:0];
        r_xlo3 <= r_xlo2;
        r_r    <= r_xlo3 - r_qq;
        r_p    <= npmac_pkg::reduce3(r_r);
    end

    assign o_p = r_p;

endmodule

>>> hw/rtl/negacyclic_poly_mac_mod_q_top.sv
// Top level of the negacyclic polynomial multiply-accumulate block mod q.
// Depends on npmac_pkg, npmac_ram and npmac_mulred.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+------------------------------------------------
//  input    | start, busy (in at !busy)| i_opcode, i_coef_index, i_coef_value, i_noise_term
//  result   | o_result_strobe (1 cycle)| o_result_value, o_result_index
//
// Load: written in the accept cycle, busy stays low. Accumulate: busy while one secret
// coefficient per cycle goes through the shared five-stage multiply-reduce unit and the
// pipeline drains. Readout: busy during the accumulator RAM read, which also clears the
// word; the word plus noise is strobed in the cycle after. After reset a clearing pass
// zeroes the accumulator RAM while busy is high. The receiver cannot stall results.
module negacyclic_poly_mac_mod_q_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [npmac_pkg::OP_W-1:0]          i_opcode,
    input  logic [npmac_pkg::IDX_W-1:0]         i_coef_index,
    input  logic [npmac_pkg::VAL_W-1:0]         i_coef_value,
    input  logic signed [npmac_pkg::NOISE_W-1:0] i_noise_term,
    output logic                                o_result_strobe,
    output logic [npmac_pkg::VAL_W-1:0]         o_result_value,
    output logic [npmac_pkg::IDX_W-1:0]         o_result_index
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_MAC   = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_RD0   = 3'd4;
    localparam logic [2:0] ST_RD1   = 3'd5;

    localparam logic [npmac_pkg::ADDR_W-1:0] LAST =
        npmac_pkg::ADDR_W'(npmac_pkg::N_COEFFS - 1);
    localparam logic [npmac_pkg::ADDR_W:0] N_EXT =
        (npmac_pkg::ADDR_W + 1)'(npmac_pkg::N_COEFFS);

    logic [2:0]                          r_state, n_state;
    logic [npmac_pkg::ADDR_W-1:0]        r_cnt, n_cnt;
    logic [npmac_pkg::ADDR_W-1:0]        r_idx, n_idx;
    logic [npmac_pkg::VAL_W-1:0]         r_val, n_val;
    logic signed [npmac_pkg::NOISE_W-1:0] r_noise, n_noise;
    logic                                r_out_vld, n_out_vld;
    logic [npmac_pkg::VAL_W-1:0]         r_out_val, n_out_val;
    logic [npmac_pkg::IDX_W-1:0]         r_out_idx, n_out_idx;
    logic [npmac_pkg::TAG_N-1:0]         r_tag_vld;
    npmac_pkg::t_tag                     r_tag [npmac_pkg::TAG_N];
    npmac_pkg::t_tag                     n_tag;
    logic                                n_tag_vld;

    logic                                accept;
    logic                                in_rng;
    logic [npmac_pkg::VAL_W-1:0]         in_val;
    logic [npmac_pkg::ADDR_W:0]          k_sum;

    logic                                sec_we;
    logic [npmac_pkg::VAL_W-1:0]         sec_rdata;
    logic                                acc_we;
    logic [npmac_pkg::ADDR_W-1:0]        acc_waddr;
    logic [npmac_pkg::VAL_W-1:0]         acc_wdata;
    logic [npmac_pkg::ADDR_W-1:0]        acc_raddr;
    logic [npmac_pkg::VAL_W-1:0]         acc_rdata;
    logic [npmac_pkg::VAL_W-1:0]         prod_mod;
    logic [npmac_pkg::WIDE_W-1:0]        wb_sum;
    logic [npmac_pkg::WIDE_W-1:0]        rd_sum;

    assign busy   = (r_state != ST_IDLE);
    assign accept = start && !busy;
    assign in_rng = (int'(i_coef_index) < npmac_pkg::N_COEFFS);
    assign in_val = npmac_pkg::reduce3({2'b00, i_coef_value});

    assign k_sum     = {1'b0, r_cnt} + {1'b0, r_idx};
    assign n_tag.wrap = (k_sum >= N_EXT);
    assign n_tag.k   = n_tag.wrap ? npmac_pkg::ADDR_W'(k_sum - N_EXT)
                                  : k_sum[npmac_pkg::ADDR_W-1:0];

    assign wb_sum = r_tag[npmac_pkg::WB_TAP].wrap
                  ? ({2'b00, acc_rdata} + npmac_pkg::Q_W - {2'b00, prod_mod})
                  : ({2'b00, acc_rdata} + {2'b00, prod_mod});
    assign rd_sum = {2'b00, acc_rdata} + npmac_pkg::Q_W
                  + {{(npmac_pkg::WIDE_W - npmac_pkg::NOISE_W){r_noise[npmac_pkg::NOISE_W-1]}},
                     r_noise};

    npmac_ram #(
        .WIDTH (npmac_pkg::VAL_W),
        .DEPTH (npmac_pkg::N_COEFFS)
    ) u_secret_ram (
        .i_clk   (i_clk),
        .i_we    (sec_we),
        .i_waddr (npmac_pkg::ADDR_W'(i_coef_index)),
        .i_wdata (in_val),
        .i_raddr (r_cnt),
        .o_rdata (sec_rdata)
    );

    npmac_ram #(
        .WIDTH (npmac_pkg::VAL_W),
        .DEPTH (npmac_pkg::N_COEFFS)
    ) u_acc_ram (
        .i_clk   (i_clk),
        .i_we    (acc_we),
        .i_waddr (acc_waddr),
        .i_wdata (acc_wdata),
        .i_raddr (acc_raddr),
        .o_rdata (acc_rdata)
    );

    npmac_mulred u_mulred (
        .i_clk (i_clk),
        .i_a   (sec_rdata),
        .i_b   (r_val),
        .o_p   (prod_mod)
    );

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_idx     = r_idx;
        n_val     = r_val;
        n_noise   = r_noise;
        n_out_vld = 1'b0;
        n_out_val = r_out_val;
        n_out_idx = r_out_idx;
        n_tag_vld = 1'b0;
        sec_we    = 1'b0;
        acc_we    = 1'b0;
        acc_waddr = r_cnt;
        acc_wdata = '0;
        acc_raddr = r_tag[npmac_pkg::RD_TAP].k;
        unique case (r_state)
            ST_CLEAR: begin
                acc_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept && in_rng) begin
                    unique case (i_opcode)
                        npmac_pkg::OP_LOAD: begin
                            sec_we = 1'b1;
                        end
                        npmac_pkg::OP_MAC: begin
                            n_state = ST_MAC;
                            n_cnt   = '0;
                            n_idx   = npmac_pkg::ADDR_W'(i_coef_index);
                            n_val   = in_val;
                        end
                        npmac_pkg::OP_READ: begin
                            n_state = ST_RD0;
                            n_idx   = npmac_pkg::ADDR_W'(i_coef_index);
                            n_noise = i_noise_term;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MAC: begin
                n_tag_vld = 1'b1;
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == LAST) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!(|r_tag_vld)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_RD0: begin
                acc_raddr = r_idx;
                n_state   = ST_RD1;
            end
            ST_RD1: begin
                acc_we    = 1'b1;
                acc_waddr = r_idx;
                n_out_vld = 1'b1;
                n_out_val = npmac_pkg::reduce3(rd_sum);
                n_out_idx = npmac_pkg::IDX_W'(r_idx);
                n_state   = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (r_tag_vld[npmac_pkg::WB_TAP]) begin
            acc_we    = 1'b1;
            acc_waddr = r_tag[npmac_pkg::WB_TAP].k;
            acc_wdata = npmac_pkg::reduce3(wb_sum);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_CLEAR;
            r_cnt     <= '0;
            r_out_vld <= 1'b0;
            r_tag_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_cnt     <= n_cnt;
            r_out_vld <= n_out_vld;
            r_tag_vld <= {r_tag_vld[npmac_pkg::TAG_N-2:0], n_tag_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx     <= n_idx;
        r_val     <= n_val;
        r_noise   <= n_noise;
        r_out_val <= n_out_val;
        r_out_idx <= n_out_idx;
        r_tag[0]  <= n_tag;
        for (int d = 1; d < npmac_pkg::TAG_N; d++) begin
            r_tag[d] <= r_tag[d-1];
        end
    end

    assign o_result_strobe = r_out_vld;
    assign o_result_value  = r_out_val;
    assign o_result_index  = r_out_idx;

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |=> !o_result_strobe)
        else $error("result strobe held for two cycles");

    a_result_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_strobe |-> (o_result_value < npmac_pkg::VAL_W'(npmac_pkg::Q_W)))
        else $error("result not reduced below q");

    a_wb_in_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag_vld[npmac_pkg::WB_TAP] |-> (r_state == ST_MAC || r_state == ST_DRAIN))
        else $error("accumulator writeback outside accumulate");

    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_we |-> (acc_wdata < npmac_pkg::VAL_W'(npmac_pkg::Q_W)))
        else $error("accumulator word not reduced below q");

endmodule
